[design/rlac_pkg.sv]
// Shared types and constants for the raster lag autocorrelation unit.
// No dependencies; used by the top level and by rlac_scan.
package rlac_pkg;

  localparam int DIM_W     = 7;     // width of the row and column count registers
  localparam int LAG_W     = 6;     // width of a signed lag offset
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;
  localparam int STAT_W    = 2;
  localparam int K_SCALE   = 1000;  // fixed-point scale of the Moran result

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIO = 2'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_VAR = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_PAIRS = 2'd2;

  // Start request from the query controller to the raster scanner.
  typedef struct packed {
    logic                    start;
    logic signed [LAG_W-1:0] row_lag;
    logic signed [LAG_W-1:0] col_lag;
  } scan_ctl_t;

endpackage

[design/raster_lag_autocorrelation_unit.sv]
// Top level of the raster lag autocorrelation unit: configuration registers,
// query sequencer and result register. Depends on rlac_pkg, rlac_scan, rlac_mul, rlac_div.
//
//   Channel  Direction  Handshake           Payload
//   cfg      in         cfg_we              cfg_index, cfg_data
//   in       in         in_valid/in_stall   in_kind, in_cell_value, in_row_lag, in_column_lag
//   out      out        out_valid/out_stall out_lag_value, out_status
//
// A load transaction writes one cell into the raster memory and leaves the unit
// ready for the next transaction. A query transaction scans the whole rows*cols
// grid, one cell pair per cycle through the two read ports of the raster memory,
// followed by the read, product and accumulate registers; the Moran path then runs
// thirteen products on the shift-add multiplier and one division, the semivariogram
// path only the division. Reset is synchronous and clears control state and the
// load pointer; the raster memory is not cleared. While the result register holds
// an untaken result the unit still accepts and works on the next transaction.
module raster_lag_autocorrelation_unit #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [rlac_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rlac_pkg::CFG_DAT_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_kind,
  input  logic signed [15:0]                     in_cell_value,
  input  logic signed [rlac_pkg::LAG_W-1:0]      in_row_lag,
  input  logic signed [rlac_pkg::LAG_W-1:0]      in_column_lag,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [31:0]                     out_lag_value,
  output logic [rlac_pkg::STAT_W-1:0]            out_status
);

  localparam int VB    = VALUE_BITS;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NB    = AW + 1;
  localparam int S1W   = VB + NB;
  localparam int S2W   = 2 * VB + NB;
  localparam int QVW   = 2 * VB + NB + 1;
  // Wide enough for 1000*n*(n*Sij - Si*Sj) and the four-term denominator.
  localparam int WW    = 2 * VB + 3 * NB + 14;
  localparam int MBW   = (S1W > 11) ? S1W : 11;
  localparam int DW    = rlac_pkg::DIM_W;

  localparam logic [DW-1:0] ROW_CAP = DW'((MAX_ROWS > 127) ? 127 : MAX_ROWS);
  localparam logic [DW-1:0] COL_CAP = DW'((MAX_COLS > 127) ? 127 : MAX_COLS);
  localparam logic [DW-1:0] ROW_RST = (ROW_CAP < DW'(64)) ? ROW_CAP : DW'(64);
  localparam logic [DW-1:0] COL_RST = (COL_CAP < DW'(64)) ? COL_CAP : DW'(64);

  // A count of zero is used as one; a count above the store size as the maximum.
  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
                                               input logic [DW-1:0] cap);
    logic [DW-1:0] res;
    res = v;
    if (v == '0) res = DW'(1);
    else if (v > cap) res = cap;
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] q);
    logic [WW-32:0]     hi;
    logic signed [31:0] res;
    hi = q[WW-1:31];
    if ((&hi) || !(|hi)) res = q[31:0];
    else if (q[WW-1])   res = 32'sh8000_0000;
    else                res = 32'sh7FFF_FFFF;
    return res;
  endfunction

  // Configuration registers
  logic [DW-1:0] rows_r;
  logic [DW-1:0] cols_r;
  logic          vario_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= ROW_RST;
      cols_r  <= COL_RST;
      vario_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlac_pkg::CFG_ROWS:  rows_r  <= clamp_dim(cfg_data, ROW_CAP);
        rlac_pkg::CFG_COLS:  cols_r  <= clamp_dim(cfg_data, COL_CAP);
        rlac_pkg::CFG_VARIO: vario_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MUL_GO, ST_MUL_WAIT, ST_ZCHK, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
  } state_t;

  // Product sequence for the Moran numerator and denominator.
  typedef enum logic [3:0] {
    MS_NSIJ, MS_SISJ, MS_TN1, MS_TK, MS_NSII, MS_SISI, MS_TN2,
    MS_QJN, MS_TN3, MS_SJSJS, MS_TN4, MS_SJSJ, MS_TKCNT
  } mstep_t;

  typedef enum logic [2:0] {
    ACT_T_SET, ACT_T_SUB, ACT_N_SET, ACT_D_SET, ACT_D_ADD, ACT_D_SUB2
  } act_t;

  state_t  state_r;
  mstep_t  step_r;

  logic signed [WW-1:0] t_r;
  logic signed [WW-1:0] d_r;
  logic signed [WW-1:0] num_r;
  logic signed [31:0]   res_val_r;
  logic [rlac_pkg::STAT_W-1:0] res_stat_r;
  logic                 out_valid_r;
  logic signed [31:0]   out_val_r;
  logic [rlac_pkg::STAT_W-1:0] out_stat_r;

  logic in_acc;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Sign-extend the cell field to 32 bits' worth and keep the low VALUE_BITS.
  logic [31:0] cell_ext;
  assign cell_ext = {{16{in_cell_value[15]}}, in_cell_value};

  rlac_pkg::scan_ctl_t scan_ctl;
  logic                scan_done;
  logic [NB-1:0]       n, k;
  logic signed [S1W-1:0] si, sj, sjs;
  logic signed [S2W-1:0] sii, sij, qj;
  logic [QVW-1:0]        qv;

  assign scan_ctl.start   = in_acc && (in_kind == rlac_pkg::KIND_QUERY);
  assign scan_ctl.row_lag = in_row_lag;
  assign scan_ctl.col_lag = in_column_lag;

  rlac_scan #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && (in_kind == rlac_pkg::KIND_LOAD)),
    .wr_data (cell_ext[VB-1:0]),
    .rows    (rows_r),
    .cols    (cols_r),
    .ctl     (scan_ctl),
    .done    (scan_done),
    .n       (n),
    .k       (k),
    .si      (si),
    .sj      (sj),
    .sjs     (sjs),
    .sii     (sii),
    .sij     (sij),
    .qj      (qj),
    .qv      (qv)
  );

  // Operand selection for the current product.
  logic signed [WW-1:0]  mul_a;
  logic signed [MBW-1:0] mul_b;
  act_t                  act;
  logic                  mul_done;
  logic signed [WW-1:0]  mul_p;

  always_comb begin
    mul_a = t_r;
    mul_b = MBW'(n);
    act   = ACT_T_SET;
    unique case (step_r)
      MS_NSIJ:  begin mul_a = WW'(sij); mul_b = MBW'(n);  act = ACT_T_SET;  end
      MS_SISJ:  begin mul_a = WW'(si);  mul_b = MBW'(sj); act = ACT_T_SUB;  end
      MS_TN1:   begin mul_a = t_r;      mul_b = MBW'(n);  act = ACT_T_SET;  end
      MS_TK:    begin mul_a = t_r;      mul_b = MBW'(rlac_pkg::K_SCALE); act = ACT_N_SET; end
      MS_NSII:  begin mul_a = WW'(sii); mul_b = MBW'(n);  act = ACT_T_SET;  end
      MS_SISI:  begin mul_a = WW'(si);  mul_b = MBW'(si); act = ACT_T_SUB;  end
      MS_TN2:   begin mul_a = t_r;      mul_b = MBW'(n);  act = ACT_D_SET;  end
      MS_QJN:   begin mul_a = WW'(qj);  mul_b = MBW'(n);  act = ACT_T_SET;  end
      MS_TN3:   begin mul_a = t_r;      mul_b = MBW'(n);  act = ACT_D_ADD;  end
      MS_SJSJS: begin mul_a = WW'(sj);  mul_b = MBW'(sjs); act = ACT_T_SET; end
      MS_TN4:   begin mul_a = t_r;      mul_b = MBW'(n);  act = ACT_D_SUB2; end
      MS_SJSJ:  begin mul_a = WW'(sj);  mul_b = MBW'(sj); act = ACT_T_SET;  end
      MS_TKCNT: begin mul_a = t_r;      mul_b = MBW'(k);  act = ACT_D_ADD;  end
      default:  ;
    endcase
  end

  rlac_mul #(
    .AW (WW),
    .BW (MBW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_MUL_GO),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  logic                 div_done;
  logic signed [WW-1:0] div_q;

  rlac_div #(
    .W (WW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_DIV_GO),
    .num   (num_r),
    .den   (d_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= MS_NSIJ;
      out_valid_r <= 1'b0;
    end else begin
      // In ST_OUT the result register is loaded below instead.
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (scan_ctl.start) state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_done) begin
            if (n == '0) begin
              res_val_r  <= '0;
              res_stat_r <= rlac_pkg::STAT_NO_PAIRS;
              state_r    <= ST_OUT;
            end else if (vario_r) begin
              // Semivariance: sum of squared differences over 2n.
              num_r   <= WW'(qv);
              d_r     <= WW'({n, 1'b0});
              state_r <= ST_DIV_GO;
            end else begin
              step_r  <= MS_NSIJ;
              state_r <= ST_MUL_GO;
            end
          end
        end
        ST_MUL_GO: begin
          state_r <= ST_MUL_WAIT;
        end
        ST_MUL_WAIT: begin
          if (mul_done) begin
            unique case (act)
              ACT_T_SET:  t_r   <= mul_p;
              ACT_T_SUB:  t_r   <= t_r - mul_p;
              ACT_N_SET:  num_r <= mul_p;
              ACT_D_SET:  d_r   <= mul_p;
              ACT_D_ADD:  d_r   <= d_r + mul_p;
              ACT_D_SUB2: d_r   <= d_r - {mul_p[WW-2:0], 1'b0};
              default: ;
            endcase
            if (step_r == MS_TKCNT) begin
              state_r <= ST_ZCHK;
            end else begin
              step_r  <= mstep_t'(step_r + 4'd1);
              state_r <= ST_MUL_GO;
            end
          end
        end
        ST_ZCHK: begin
          // An exactly zero denominator means no variance at this lag.
          if (d_r == '0) begin
            res_val_r  <= 32'(rlac_pkg::K_SCALE);
            res_stat_r <= rlac_pkg::STAT_ZERO_VAR;
            state_r    <= ST_OUT;
          end else begin
            state_r <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            res_val_r  <= sat32(div_q);
            res_stat_r <= rlac_pkg::STAT_OK;
            state_r    <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Wait here only while the previous result is still not taken.
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_val_r   <= res_val_r;
            out_stat_r  <= res_stat_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lag_value = out_val_r;
  assign out_status    = out_stat_r;

endmodule

[design/rlac_mul.sv]
// Shift-add signed multiplier, one multiplier bit per cycle.
// Depends on nothing; used by the top level for the wide moment products.
module rlac_mul #(
  parameter int AW = 85,
  parameter int BW = 29
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic                 done,
  output logic signed [AW-1:0] p
);

  localparam int CNTW = (BW > 1) ? $clog2(BW) : 1;

  logic signed [AW-1:0] a_sh_r;
  logic        [BW-1:0] b_sh_r;
  logic signed [AW-1:0] acc_r;
  logic [CNTW-1:0]      cnt_r;
  logic                 busy_r;
  logic                 done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_sh_r <= a;
        b_sh_r <= b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // The top bit of b carries negative weight.
        if (b_sh_r[0]) begin
          if (cnt_r == CNTW'(BW - 1)) acc_r <= acc_r - a_sh_r;
          else                        acc_r <= acc_r + a_sh_r;
        end
        a_sh_r <= a_sh_r <<< 1;
        b_sh_r <= b_sh_r >> 1;
        if (cnt_r == CNTW'(BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

[design/rlac_div.sv]
// Restoring signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on nothing; used by the top level for the final ratio.
module rlac_div #(
  parameter int W = 85
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic                done,
  output logic signed [W-1:0] quo
);

  localparam int CNTW = $clog2(W);

  logic [W-1:0]    ua_r;
  logic [W-1:0]    ud_r;
  logic [W:0]      rem_r;
  logic [CNTW-1:0] cnt_r;
  logic            neg_r;
  logic            busy_r;
  logic            done_r;
  logic [W:0]      trial;
  logic            qbit;

  assign trial = {rem_r[W-1:0], ua_r[W-1]};
  assign qbit  = (trial >= {1'b0, ud_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r  <= num[W-1] ^ den[W-1];
        ua_r   <= num[W-1] ? -num : num;
        ud_r   <= den[W-1] ? -den : den;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= qbit ? (trial - {1'b0, ud_r}) : trial;
        ua_r  <= {ua_r[W-2:0], qbit};
        if (cnt_r == CNTW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -ua_r : ua_r;

endmodule

[design/rlac_scan.sv]
// Raster store with its load pointer, and the lag scan that gathers pair moments.
// Depends on rlac_pkg; instantiated by the top level.
module rlac_scan #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         wr_en,
  input  logic [VALUE_BITS-1:0]                        wr_data,
  input  logic [rlac_pkg::DIM_W-1:0]                   rows,
  input  logic [rlac_pkg::DIM_W-1:0]                   cols,
  input  rlac_pkg::scan_ctl_t                          ctl,
  output logic                                         done,
  output logic [$clog2(MAX_ROWS*MAX_COLS):0]           n,
  output logic [$clog2(MAX_ROWS*MAX_COLS):0]           k,
  output logic signed [VALUE_BITS+$clog2(MAX_ROWS*MAX_COLS):0]   si,
  output logic signed [VALUE_BITS+$clog2(MAX_ROWS*MAX_COLS):0]   sj,
  output logic signed [VALUE_BITS+$clog2(MAX_ROWS*MAX_COLS):0]   sjs,
  output logic signed [2*VALUE_BITS+$clog2(MAX_ROWS*MAX_COLS):0] sii,
  output logic signed [2*VALUE_BITS+$clog2(MAX_ROWS*MAX_COLS):0] sij,
  output logic signed [2*VALUE_BITS+$clog2(MAX_ROWS*MAX_COLS):0] qj,
  output logic [2*VALUE_BITS+$clog2(MAX_ROWS*MAX_COLS)+1:0]      qv
);

  localparam int VB    = VALUE_BITS;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NB    = AW + 1;
  localparam int S1W   = VB + NB;
  localparam int S2W   = 2 * VB + NB;
  localparam int QVW   = 2 * VB + NB + 1;
  localparam int DW    = rlac_pkg::DIM_W;
  localparam int OFFW  = 16;
  localparam int CMPW  = AW + 2 * DW + 1;

  logic [VB-1:0] mem [DEPTH];

  // Load side
  logic [AW-1:0]     lp_r;
  logic [2*DW-1:0]   rc;
  logic [AW-1:0]     wa;
  logic [AW:0]       wa_inc;

  assign rc     = rows * cols;
  assign wa     = (CMPW'(lp_r) >= CMPW'(rc)) ? '0 : lp_r;
  assign wa_inc = {1'b0, wa} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= '0;
    end else if (wr_en) begin
      lp_r <= (CMPW'(wa_inc) >= CMPW'(rc)) ? '0 : wa_inc[AW-1:0];
    end
  end

  // Scan side
  logic [DW-1:0]                   r_r;
  logic [DW-1:0]                   c_r;
  logic [AW-1:0]                   lin_r;
  logic [AW-1:0]                   off_r;
  logic signed [rlac_pkg::LAG_W-1:0] dy_r;
  logic signed [rlac_pkg::LAG_W-1:0] dx_r;
  logic                            act_r;

  logic signed [OFFW-1:0]    off;
  logic signed [AW+OFFW-1:0] off_big;
  logic signed [DW+1:0]      rr;
  logic signed [DW+1:0]      cc;
  logic signed [DW+2:0]      rr2;
  logic signed [DW+2:0]      cc2;
  logic                      pair_ok;
  logic                      leaves;
  logic                      last;
  logic [AW-1:0]             aj;

  assign off = $signed({{(OFFW-rlac_pkg::LAG_W){ctl.row_lag[rlac_pkg::LAG_W-1]}}, ctl.row_lag})
             * $signed({{(OFFW-DW){1'b0}}, cols})
             + $signed({{(OFFW-rlac_pkg::LAG_W){ctl.col_lag[rlac_pkg::LAG_W-1]}}, ctl.col_lag});
  assign off_big = (AW+OFFW)'(off);

  assign rr  = $signed({2'b00, r_r}) + $signed({{3{dy_r[rlac_pkg::LAG_W-1]}}, dy_r});
  assign cc  = $signed({2'b00, c_r}) + $signed({{3{dx_r[rlac_pkg::LAG_W-1]}}, dx_r});
  assign rr2 = $signed({rr[DW+1], rr}) + $signed({{4{dy_r[rlac_pkg::LAG_W-1]}}, dy_r});
  assign cc2 = $signed({cc[DW+1], cc}) + $signed({{4{dx_r[rlac_pkg::LAG_W-1]}}, dx_r});

  assign pair_ok = !rr[DW+1] && (rr < $signed({2'b00, rows}))
                && !cc[DW+1] && (cc < $signed({2'b00, cols}));
  assign leaves  = rr2[DW+2] || (rr2 >= $signed({3'b000, rows}))
                || cc2[DW+2] || (cc2 >= $signed({3'b000, cols}));
  assign last    = (r_r == rows - 1'b1) && (c_r == cols - 1'b1);
  assign aj      = lin_r + off_r;

  // Pipeline: issue reads, form products, accumulate.
  logic                 p1_v, p1_k, p1_last;
  logic [VB-1:0]        rd_i_r, rd_j_r;
  logic                 p2_v, p2_k, p2_last;
  logic signed [VB-1:0]   p2_zi, p2_zj;
  logic signed [2*VB-1:0] p2_ii, p2_ij, p2_jj;
  logic [2*VB+1:0]        p2_dd;
  logic signed [VB-1:0]   zi, zj;
  logic signed [VB:0]     dif;
  logic                   done_r;

  assign zi  = rd_i_r;
  assign zj  = rd_j_r;
  assign dif = VB'(0) + (VB+1)'(zi) - (VB+1)'(zj);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wa] <= wr_data;
    rd_i_r <= mem[lin_r];
    rd_j_r <= mem[aj];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      p1_v    <= 1'b0;
      p1_k    <= 1'b0;
      p1_last <= 1'b0;
      p2_v    <= 1'b0;
      p2_k    <= 1'b0;
      p2_last <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      p1_v    <= act_r && pair_ok;
      p1_k    <= act_r && pair_ok && leaves;
      p1_last <= act_r && last;
      p2_v    <= p1_v;
      p2_k    <= p1_k;
      p2_last <= p1_last;
      done_r  <= p2_last;
      if (ctl.start) begin
        act_r <= 1'b1;
        r_r   <= '0;
        c_r   <= '0;
        lin_r <= '0;
        dy_r  <= ctl.row_lag;
        dx_r  <= ctl.col_lag;
        off_r <= off_big[AW-1:0];
      end else if (act_r) begin
        lin_r <= lin_r + 1'b1;
        if (last) begin
          act_r <= 1'b0;
        end else if (c_r == cols - 1'b1) begin
          c_r <= '0;
          r_r <= r_r + 1'b1;
        end else begin
          c_r <= c_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p2_zi <= zi;
    p2_zj <= zj;
    p2_ii <= zi * zi;
    p2_ij <= zi * zj;
    p2_jj <= zj * zj;
    p2_dd <= dif * dif;
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      n   <= '0;
      k   <= '0;
      si  <= '0;
      sj  <= '0;
      sjs <= '0;
      sii <= '0;
      sij <= '0;
      qj  <= '0;
      qv  <= '0;
    end else if (p2_v) begin
      n   <= n + 1'b1;
      si  <= si + S1W'(p2_zi);
      sj  <= sj + S1W'(p2_zj);
      sii <= sii + S2W'(p2_ii);
      sij <= sij + S2W'(p2_ij);
      qv  <= qv + QVW'(p2_dd);
      if (p2_k) begin
        k   <= k + 1'b1;
        sjs <= sjs + S1W'(p2_zj);
        qj  <= qj + S2W'(p2_jj);
      end
    end
  end

  assign done = done_r;

endmodule

[tb/testbench.sv]
// Self-checking testbench for raster_lag_autocorrelation_unit.
// Depends on rlac_pkg and the design sources. It predicts each query answer from its own
// copy of the raster and the registers, and checks every result in order.
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [255:0] wide_t;

  // One expected answer of a query.
  typedef struct {
    logic signed [31:0]          lag_value;
    logic [rlac_pkg::STAT_W-1:0] status;
  } lag_answer_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [rlac_pkg::CFG_IDX_W-1:0]    cfg_index = rlac_pkg::CFG_ROWS;
  logic [rlac_pkg::CFG_DAT_W-1:0]    cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_kind = rlac_pkg::KIND_LOAD;
  logic signed [15:0]                in_cell_value = '0;
  logic signed [rlac_pkg::LAG_W-1:0] in_row_lag = '0;
  logic signed [rlac_pkg::LAG_W-1:0] in_column_lag = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [31:0]                out_lag_value;
  logic [rlac_pkg::STAT_W-1:0]       out_status;

  raster_lag_autocorrelation_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_cell_value(in_cell_value), .in_row_lag(in_row_lag), .in_column_lag(in_column_lag),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_lag_value(out_lag_value), .out_status(out_status)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the block's state: the raster, the load pointer and the registers.
  logic signed [15:0] shadow_raster [0:4095];
  int                 shadow_ptr = 0;
  int                 grid_rows = 64;
  int                 grid_cols = 64;
  bit                 vario_on = 1'b0;

  lag_answer_t answer_q[$];   // answers still owed by the block
  int  mismatches = 0;
  int  answers_seen = 0;
  int  loads_sent = 0;
  int  queries_sent = 0;
  bit  idle_en = 1'b1;        // random idling on both sides
  int  hold_req = 0;          // long receiver hold-off, picked up by the receiver process

  // Register value as the block uses it: zero means one, anything above the maximum clamps.
  function automatic int clamp_dim(logic [rlac_pkg::CFG_DAT_W-1:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  // Exact Moran or semivariogram answer for one lag over the shadow raster.
  function automatic lag_answer_t lag_statistic(int dy, int dx);
    lag_answer_t a;
    longint si, sj, sjs, n, k, zi, zj, sii, sij, qj, qv;
    wide_t wn, wk, num, den, q;
    si = 0; sj = 0; sjs = 0; n = 0; k = 0; sii = 0; sij = 0; qj = 0; qv = 0;
    for (int r = 0; r < grid_rows; r++) begin
      if (r + dy < 0 || r + dy >= grid_rows) continue;
      for (int c = 0; c < grid_cols; c++) begin
        if (c + dx < 0 || c + dx >= grid_cols) continue;
        zi = shadow_raster[r * grid_cols + c];
        zj = shadow_raster[(r + dy) * grid_cols + c + dx];
        n++;
        qv += (zi - zj) * (zi - zj);
        si += zi; sj += zj;
        sii += zi * zi;
        sij += zi * zj;
        // The second variance only counts pairs whose double-lag cell leaves the grid.
        if (r + 2 * dy >= grid_rows || r + 2 * dy < 0 ||
            c + 2 * dx >= grid_cols || c + 2 * dx < 0) begin
          k++;
          sjs += zj;
          qj += zj * zj;
        end
      end
    end
    if (n == 0) begin
      a.lag_value = 0;
      a.status = rlac_pkg::STAT_NO_PAIRS;
      return a;
    end
    a.status = rlac_pkg::STAT_OK;
    if (vario_on) begin
      q = wide_t'(qv) / wide_t'(2 * n);
    end else begin
      wn = n;
      wk = k;
      num = wide_t'(rlac_pkg::K_SCALE) * wn
          * (wn * wide_t'(sij) - wide_t'(si) * wide_t'(sj));
      den = wn * (wn * wide_t'(sii) - wide_t'(si) * wide_t'(si))
          + wn * wn * wide_t'(qj)
          - wide_t'(2) * wn * wide_t'(sj) * wide_t'(sjs)
          + wk * wide_t'(sj) * wide_t'(sj);
      if (den == 0) begin
        a.lag_value = rlac_pkg::K_SCALE;
        a.status = rlac_pkg::STAT_ZERO_VAR;
        return a;
      end
      q = num / den;
    end
    if (q > wide_t'(32'sh7FFFFFFF)) a.lag_value = 32'sh7FFFFFFF;
    else if (q < -wide_t'(64'sd2147483648)) a.lag_value = 32'sh80000000;
    else a.lag_value = q[31:0];
    return a;
  endfunction

  // Updates the shadow for one accepted transaction and records any owed answer.
  function automatic void absorb_item(logic kind, logic signed [15:0] value,
                                      logic signed [rlac_pkg::LAG_W-1:0] rl,
                                      logic signed [rlac_pkg::LAG_W-1:0] cl);
    if (kind == rlac_pkg::KIND_LOAD) begin
      if (shadow_ptr >= grid_rows * grid_cols) shadow_ptr = 0;
      shadow_raster[shadow_ptr] = value;
      shadow_ptr++;
      if (shadow_ptr >= grid_rows * grid_cols) shadow_ptr = 0;
      loads_sent++;
    end else begin
      answer_q.push_back(lag_statistic(int'(rl), int'(cl)));
      queries_sent++;
    end
  endfunction

  // Sends one transaction, idling first at random, and returns once it is accepted.
  task automatic send_item(logic kind, logic signed [15:0] value,
                           logic signed [rlac_pkg::LAG_W-1:0] rl,
                           logic signed [rlac_pkg::LAG_W-1:0] cl);
    while (idle_en && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_cell_value <= value;
    in_row_lag    <= rl;
    in_column_lag <= cl;
    do @(posedge clk); while (in_stall !== 1'b0);
    absorb_item(kind, value, rl, cl);
  endtask

  task automatic send_query(int rl, int cl);
    send_item(rlac_pkg::KIND_QUERY, 16'($urandom), rlac_pkg::LAG_W'(rl),
              rlac_pkg::LAG_W'(cl));
  endtask

  // Loads one full grid; with the wrapping pointer this touches every cell in use.
  task automatic load_grid(int lo, int hi);
    for (int i = 0; i < grid_rows * grid_cols; i++)
      send_item(rlac_pkg::KIND_LOAD, 16'($urandom_range(hi - lo) + lo),
                rlac_pkg::LAG_W'($urandom), rlac_pkg::LAG_W'($urandom));
  endtask

  // Lowers valid and waits until every owed answer has come back, plus a short margin
  // because a load never produces an answer.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [rlac_pkg::CFG_IDX_W-1:0] idx,
                           logic [rlac_pkg::CFG_DAT_W-1:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      rlac_pkg::CFG_ROWS:  grid_rows = clamp_dim(data);
      rlac_pkg::CFG_COLS:  grid_cols = clamp_dim(data);
      rlac_pkg::CFG_VARIO: vario_on = data[0];
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [rlac_pkg::CFG_DAT_W-1:0] r,
                          logic [rlac_pkg::CFG_DAT_W-1:0] c, bit vario);
    write_reg(rlac_pkg::CFG_ROWS, r);
    write_reg(rlac_pkg::CFG_COLS, c);
    write_reg(rlac_pkg::CFG_VARIO, {{(rlac_pkg::CFG_DAT_W-1){1'b0}}, vario});
  endtask

  // Column count and Moran mode as left by reset, with only the row count written.
  task automatic test_full_size_defaults();
    write_reg(rlac_pkg::CFG_ROWS, 1);
    load_grid(-32768, 32767);
    send_query(0, 1);
    send_query(0, -5);
    send_query(0, -32);
    send_query(1, 0);
  endtask

  // Zero registers clamp to a single cell: zero variance at lag zero, no pairs otherwise.
  task automatic test_single_cell();
    set_grid(0, 0, 1'b0);
    send_item(rlac_pkg::KIND_LOAD, 16'sh7FFF, '0, '0);
    send_query(0, 0);
    send_query(1, 0);
    send_query(-32, 31);
    write_reg(rlac_pkg::CFG_VARIO, 1);
    send_query(0, 0);
  endtask

  // Field extremes in both modes, an over-range column count, and lags past the grid.
  task automatic test_extremes();
    set_grid(2, 3, 1'b0);
    for (int i = 0; i < grid_rows * grid_cols; i++)
      send_item(rlac_pkg::KIND_LOAD, (i % 2) ? 16'sh8000 : 16'sh7FFF, '0, '0);
    send_query(0, 1);
    send_query(1, -1);
    send_query(31, 0);
    send_query(0, -32);
    write_reg(rlac_pkg::CFG_VARIO, 1);
    send_query(0, 1);
    send_query(-1, 0);
    // One row of the full width; every cell of it was loaded earlier.
    set_grid(1, 127, 1'b0);
    send_query(0, 31);
    send_query(0, -1);
  endtask

  // Random small grids, random content and random lags, most of them inside the grid.
  task automatic test_random_grids(int phases);
    int rl, cl;
    for (int p = 0; p < phases; p++) begin
      set_grid(rlac_pkg::CFG_DAT_W'($urandom_range(4, 1)),
               rlac_pkg::CFG_DAT_W'($urandom_range(4, 1)), 1'($urandom_range(1)));
      if ($urandom_range(3) == 0) load_grid(-2, 2);
      else load_grid(-32768, 32767);
      repeat ($urandom_range(6, 3)) begin
        if ($urandom_range(4) == 0) begin
          rl = $urandom_range(63) - 32;
          cl = $urandom_range(63) - 32;
        end else begin
          rl = $urandom_range(2 * grid_rows) - grid_rows;
          cl = $urandom_range(2 * grid_cols) - grid_cols;
        end
        send_query(rl, cl);
        if ($urandom_range(2) == 0)
          send_item(rlac_pkg::KIND_LOAD, 16'($urandom), rlac_pkg::LAG_W'($urandom),
                    rlac_pkg::LAG_W'($urandom));
      end
    end
  endtask

  // The receiver holds off for a long stretch while queries keep coming, so the block
  // fills up and stalls its input; then the sender pauses until everything drained.
  task automatic test_backpressure();
    set_grid(3, 3, 1'b0);
    load_grid(-32768, 32767);
    idle_en = 1'b0;
    hold_req = 6000;
    for (int i = 0; i < 8; i++) send_query($urandom_range(4) - 2, $urandom_range(4) - 2);
    wait_drained();
    for (int i = 0; i < 4; i++) send_query($urandom_range(6) - 3, $urandom_range(6) - 3);
    idle_en = 1'b1;
  endtask

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < 15);
      end
    end
  end

  // Result checker: each accepted result is matched against the oldest owed answer.
  always @(posedge clk) begin
    lag_answer_t exp_a;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      answers_seen++;
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result value=%0d status=%0d", out_lag_value, out_status);
      end else begin
        exp_a = answer_q.pop_front();
        if (out_lag_value !== exp_a.lag_value || out_status !== exp_a.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected value=%0d status=%0d, got value=%0d status=%0d",
                     answers_seen, exp_a.lag_value, exp_a.status, out_lag_value, out_status);
        end
      end
    end
  end

  initial begin
    int tail;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_full_size_defaults();
    test_single_cell();
    test_extremes();
    test_backpressure();
    test_random_grids(3);
    in_valid <= 1'b0;
    tail = 0;
    while (answer_q.size() != 0 && tail < 200000) begin
      @(posedge clk);
      tail++;
    end
    repeat (100) @(posedge clk);
    if (answer_q.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d answers never arrived", answer_q.size());
    end
    $display("Covered %0d loads and %0d lag queries over default, degenerate and random grids,",
             loads_sent, queries_sent);
    $display("both modes, lag extremes and a long receiver hold-off; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #40ms;
    $display("ERROR: timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
